[hdl/rfa_pkg.sv]
// ----------------------------------------------------------------------------
// rfa_pkg: shared types and codes for the rational fraction ALU
// Request and result structs, command and status codes, and the
// controller-to-datapath command and status bundles.
// ----------------------------------------------------------------------------
package rfa_pkg;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_OVF = 2'd3;

  typedef struct packed {
    logic [1:0]        command;
    logic signed [31:0] a_numerator;
    logic signed [31:0] a_denominator;
    logic signed [31:0] b_numerator;
    logic signed [31:0] b_denominator;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_numerator;
    logic [30:0]        result_denominator;
    logic [1:0]         status;
  } rsp_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;     // capture request, decode operands
    logic mul;      // form one partial product
    logic comb;     // combine products into n, d
    logic gcd_init; // strip common twos
    logic gcd_step; // one binary gcd step
    logic div_step; // one restoring division bit
    logic finish;   // range check and pack result
  } ctl_t;

  // datapath -> controller status
  typedef struct packed {
    logic early;    // request ends in an input error
    logic mul_done;
    logic two_done; // gb is odd or ga is zero
    logic gcd_done;
    logic div_done;
  } sts_t;

endpackage

[hdl/rfa_datapath.sv]
// ----------------------------------------------------------------------------
// rfa_datapath: operand decode, multiply, binary gcd and quotient unit
// Sign-magnitude products are formed one 32x32 multiply per cycle. The gcd
// runs one subtract/shift step per cycle; reduction divides n and d by the
// gcd in parallel, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rfa_datapath #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rfa_pkg::req_t req_i,
  input  rfa_pkg::ctl_t ctl_i,
  output rfa_pkg::sts_t sts_o,
  output rfa_pkg::rsp_t rsp_o
);

  localparam int unsigned W = DATA_WIDTH;
  localparam int unsigned PW = 2 * DATA_WIDTH;
  localparam int unsigned CW = $clog2(PW + 1);

  // decoded operand magnitudes and signs
  logic [W:0]  an_q, ad_q, bn_q, bd_q;
  logic        an_s_q, bn_s_q;
  logic [1:0]  cmd_q;
  logic [1:0]  err_q;
  // products
  logic [PW-1:0] p_q [3];
  logic [1:0]    pi_q;
  // reduction state
  logic [PW:0]   nm_q, dm_q, ga_q, gb_q;
  logic          ns_q;
  logic [CW-1:0] k_q, bit_q;
  logic [PW:0]   qn_q, qd_q, rn_q, rd_q, g_q;
  rfa_pkg::rsp_t rsp_q;

  function automatic logic [W:0] mag_f(input logic [31:0] v);
    logic [W-1:0] m;
    begin
      m = v[W-1:0];
      mag_f = m[W-1] ? ({1'b0, ~m} + 1'b1) : {1'b0, m};
    end
  endfunction

  logic [W:0] an_m, ad_m, bn_m, bd_m;
  logic       an_n, ad_n, bn_n, bd_n;
  assign an_m = mag_f(req_i.a_numerator);
  assign ad_m = mag_f(req_i.a_denominator);
  assign bn_m = mag_f(req_i.b_numerator);
  assign bd_m = mag_f(req_i.b_denominator);
  assign an_n = req_i.a_numerator[W-1];
  assign ad_n = req_i.a_denominator[W-1];
  assign bn_n = req_i.b_numerator[W-1];
  assign bd_n = req_i.b_denominator[W-1];

  // select multiplier operands: 0 an*bd (an*bn for mul), 1 ad*bd (ad*bn for div), 2 bn*ad
  logic [W:0] mx, my;
  always_comb begin
    mx = an_q;
    my = bd_q;
    case (pi_q)
      2'd0: begin
        mx = an_q;
        my = (cmd_q == rfa_pkg::CMD_MUL) ? bn_q : bd_q;
      end
      2'd1: begin
        mx = ad_q;
        my = (cmd_q == rfa_pkg::CMD_DIV) ? bn_q : bd_q;
      end
      2'd2: begin
        mx = bn_q;
        my = ad_q;
      end
      default: begin
        mx = an_q;
        my = bd_q;
      end
    endcase
  end
  logic [2*W+1:0] mprod;
  assign mprod = mx * my;

  // combine: n magnitude/sign, d magnitude
  logic          s0, s1;
  logic [PW:0]   n_c, d_c;
  logic          ns_c;
  always_comb begin
    s0 = 1'b0;
    s1 = 1'b0;
    n_c = {1'b0, p_q[0]};
    ns_c = 1'b0;
    d_c = {1'b0, p_q[1]};
    case (cmd_q)
      rfa_pkg::CMD_MUL, rfa_pkg::CMD_DIV: begin
        ns_c = (an_s_q ^ bn_s_q) && (p_q[0] != '0);
      end
      default: begin
        s0 = an_s_q;
        s1 = bn_s_q ^ (cmd_q == rfa_pkg::CMD_SUB);
        if (s0 == s1) begin
          n_c = {1'b0, p_q[0]} + {1'b0, p_q[2]};
          ns_c = s0;
        end else if (p_q[0] >= p_q[2]) begin
          n_c = {1'b0, p_q[0] - p_q[2]};
          ns_c = s0;
        end else begin
          n_c = {1'b0, p_q[2] - p_q[0]};
          ns_c = s1;
        end
        if (n_c == '0) ns_c = 1'b0;
      end
    endcase
  end

  // binary gcd step on ga/gb (gb odd or ga zero after init)
  logic ga_odd, gb_odd;
  assign ga_odd = ga_q[0];
  assign gb_odd = gb_q[0];

  // restoring division trial
  logic [PW+1:0] tn, td;
  assign tn = {rn_q, qn_q[PW]} - {1'b0, g_q};
  assign td = {rd_q, qd_q[PW]} - {1'b0, g_q};

  // result check
  logic [PW:0] lim_c;
  assign lim_c = {{(PW-W+1){1'b0}}, 1'b1, {(W-1){1'b0}}};
  logic        ovf_c;
  logic [W-1:0] num_w;
  assign ovf_c = (qd_q > lim_c - 1'b1) ||
                 (qn_q > (ns_q && qn_q != '0 ? lim_c : lim_c - 1'b1));
  assign num_w = (ns_q && qn_q != '0) ? (~qn_q[W-1:0] + 1'b1) : qn_q[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pi_q <= '0;
      k_q <= '0;
      bit_q <= '0;
    end else begin
      if (ctl_i.load) begin
        pi_q <= '0;
      end else if (ctl_i.mul) begin
        pi_q <= pi_q + 2'd1;
      end
      if (ctl_i.gcd_init) begin
        if (!ga_q[0] && !gb_q[0] && ga_q != '0) k_q <= k_q + 1'b1;
      end else if (ctl_i.comb) begin
        k_q <= '0;
      end
      if (ctl_i.gcd_step && ga_q == '0) begin
        bit_q <= CW'(PW + 1);
      end else if (ctl_i.div_step) begin
        bit_q <= bit_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // capture request
    if (ctl_i.load) begin
      cmd_q <= req_i.command;
      an_q <= an_m;
      ad_q <= ad_m;
      bn_q <= bn_m;
      bd_q <= bd_m;
      an_s_q <= (an_n ^ ad_n) && (an_m != '0);
      bn_s_q <= (bn_n ^ bd_n) && (bn_m != '0);
      if (ad_m == '0 || bd_m == '0) err_q <= rfa_pkg::ST_ZDEN;
      else if (req_i.command == rfa_pkg::CMD_DIV && bn_m == '0) err_q <= rfa_pkg::ST_DIVZ;
      else err_q <= rfa_pkg::ST_OK;
    end
    // products
    if (ctl_i.mul) p_q[pi_q] <= mprod[PW-1:0];
    // combine
    if (ctl_i.comb) begin
      nm_q <= n_c;
      dm_q <= d_c;
      ns_q <= ns_c;
      ga_q <= n_c;
      gb_q <= d_c;
    end
    // remove factors of two; the common ones are counted in k_q
    if (ctl_i.gcd_init && ga_q != '0) begin
      if (!ga_odd && !gb_odd) begin
        ga_q <= ga_q >> 1;
        gb_q <= gb_q >> 1;
      end else if (!ga_odd) begin
        ga_q <= ga_q >> 1;
      end else if (!gb_odd) begin
        gb_q <= gb_q >> 1;
      end
    end
    // binary gcd: gb stays odd, ga reaches zero
    if (ctl_i.gcd_step) begin
      if (ga_q == '0) begin
        g_q <= gb_q << k_q;
        qn_q <= nm_q;
        qd_q <= dm_q;
        rn_q <= '0;
        rd_q <= '0;
      end else if (!ga_odd) begin
        ga_q <= ga_q >> 1;
      end else if (ga_q >= gb_q) begin
        ga_q <= (ga_q - gb_q) >> 1;
      end else begin
        gb_q <= ga_q;
        ga_q <= (gb_q - ga_q) >> 1;
      end
    end
    // long division of n and d by g
    if (ctl_i.div_step) begin
      if (!tn[PW+1]) begin
        rn_q <= tn[PW:0];
        qn_q <= {qn_q[PW-1:0], 1'b1};
      end else begin
        rn_q <= {rn_q[PW-1:0], qn_q[PW]};
        qn_q <= {qn_q[PW-1:0], 1'b0};
      end
      if (!td[PW+1]) begin
        rd_q <= td[PW:0];
        qd_q <= {qd_q[PW-1:0], 1'b1};
      end else begin
        rd_q <= {rd_q[PW-1:0], qd_q[PW]};
        qd_q <= {qd_q[PW-1:0], 1'b0};
      end
    end
    // pack result
    if (ctl_i.finish) begin
      if (err_q != rfa_pkg::ST_OK) begin
        rsp_q.result_numerator <= '0;
        rsp_q.result_denominator <= 31'd1;
        rsp_q.status <= err_q;
      end else if (ovf_c) begin
        rsp_q.result_numerator <= '0;
        rsp_q.result_denominator <= 31'd1;
        rsp_q.status <= rfa_pkg::ST_OVF;
      end else begin
        rsp_q.status <= rfa_pkg::ST_OK;
        rsp_q.result_numerator <= 32'(signed'(num_w));
        rsp_q.result_denominator <= 31'(qd_q[W-1:0]);
      end
    end
  end

  assign sts_o.early = (err_q != rfa_pkg::ST_OK);
  assign sts_o.mul_done = (pi_q == 2'd2);
  assign sts_o.two_done = gb_q[0] || (ga_q == '0);
  assign sts_o.gcd_done = (ga_q == '0);
  assign sts_o.div_done = (bit_q == CW'(1));
  assign rsp_o = rsp_q;

endmodule

[hdl/rfa_ctrl.sv]
// ----------------------------------------------------------------------------
// rfa_ctrl: sequencing state machine
// Walks load, check, multiply, combine, gcd and division phases, then strobes
// the result for one cycle; an input error goes from the check to finish.
// ----------------------------------------------------------------------------
module rfa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  rfa_pkg::sts_t sts_i,
  output rfa_pkg::ctl_t ctl_o,
  output logic          busy_o,
  output logic          done_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CHK  = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_COMB = 9'b000001000,
    S_TWO  = 9'b000010000,
    S_GCD  = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    ctl_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          state_d = S_CHK;
        end
      end
      S_CHK: state_d = sts_i.early ? S_FIN : S_MUL;
      S_MUL: begin
        ctl_o.mul = 1'b1;
        if (sts_i.mul_done) state_d = S_COMB;
      end
      S_COMB: begin
        ctl_o.comb = 1'b1;
        state_d = S_TWO;
      end
      S_TWO: begin
        // drop factors of two until gb is odd or ga is zero
        ctl_o.gcd_init = 1'b1;
        if (sts_i.two_done) state_d = S_GCD;
      end
      S_GCD: begin
        ctl_o.gcd_step = 1'b1;
        if (sts_i.gcd_done) state_d = S_DIV;
      end
      S_DIV: begin
        ctl_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = S_FIN;
      end
      S_FIN: begin
        ctl_o.finish = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_OUT);

endmodule

[hdl/rational_fraction_alu_unit.sv]
// ----------------------------------------------------------------------------
// rational_fraction_alu_unit: signed fraction add/sub/mul/div with reduction
// Sequence: multiply, combine, binary gcd (one shift or subtract step per cycle
// over the 2*DATA_WIDTH bit products) and division, then the result strobe.
// An input error goes from the check straight to packing the result.
// Throughput: one request at a time; busy stays high through the strobe cycle.
// Reset: asynchronous, active low; returns the controller to idle.
// ----------------------------------------------------------------------------
module rational_fraction_alu_unit #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rfa_pkg::req_t req_i,
  output logic          done_o,
  output rfa_pkg::rsp_t rsp_o
);

  rfa_pkg::ctl_t ctl;
  rfa_pkg::sts_t sts;

  // sequencing
  rfa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy_o (busy),
    .done_o (done_o)
  );

  // arithmetic
  rfa_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .ctl_i (ctl),
    .sts_o (sts),
    .rsp_o (rsp_o)
  );

endmodule

[hdl/rfa_checker.sv]
// ----------------------------------------------------------------------------
// rfa_checker: port-level checks for the rational fraction ALU
// Watches request acceptance, busy and the result strobe.
// ----------------------------------------------------------------------------
module rfa_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done,
  input rfa_pkg::rsp_t rsp_o
);

  // accepted request raises busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("busy not raised");

  // strobe is one cycle wide
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !done) else $error("done too long");

  // busy falls after the strobe
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !busy) else $error("busy after done");

  // error results are 0/1
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && rsp_o.status != rfa_pkg::ST_OK) |->
      (rsp_o.result_numerator == '0 && rsp_o.result_denominator == 31'd1))
    else $error("error result not 0/1");

  // good results have nonzero denominator
  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && rsp_o.status == rfa_pkg::ST_OK) |-> rsp_o.result_denominator != '0)
    else $error("zero denominator");

endmodule

bind rational_fraction_alu_unit rfa_checker u_rfa_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done  (done_o),
  .rsp_o (rsp_o)
);

[tb/rfa_checker.sv]
// ----------------------------------------------------------------------------
// rfa_scoreboard: scoreboard for the rational fraction ALU
// Watches accepted requests, computes the reduced fraction and status for
// each, and compares every result strobe with the oldest pending answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rfa_scoreboard (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          busy,
  input  rfa_pkg::req_t req_i,
  input  logic          done,
  input  rfa_pkg::rsp_t rsp_o,
  output int            fail_count_o,
  output int            pending_o
);
  import rfa_pkg::*;

  rsp_t answer_q[$];
  int   fail_count;

  assign fail_count_o = fail_count;
  assign pending_o = answer_q.size();

  // Split a 32-bit field into sign and magnitude
  function automatic void split(input logic [31:0] v, output bit neg,
                                output logic [63:0] mag);
    neg = v[31];
    mag = v[31] ? 64'(33'h1_0000_0000 - {1'b0, v}) : {32'd0, v};
  endfunction

  function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Compute the reduced fraction for one request
  function automatic rsp_t reduce_fraction(input req_t r);
    rsp_t o;
    bit an_s, ad_s, bn_s, bd_s, n_s, p_s, q_s;
    logic [63:0] an, ad, bn, bd, nm, dm, g, p, q;
    o = '{result_numerator: '0, result_denominator: 31'd1, status: ST_OK};
    split(r.a_numerator, an_s, an);
    split(r.a_denominator, ad_s, ad);
    split(r.b_numerator, bn_s, bn);
    split(r.b_denominator, bd_s, bd);
    if (ad == 0 || bd == 0) begin
      o.status = ST_ZDEN;
      return o;
    end
    if (r.command == CMD_DIV && bn == 0) begin
      o.status = ST_DIVZ;
      return o;
    end
    an_s = (an_s != ad_s) && an != 0;
    bn_s = (bn_s != bd_s) && bn != 0;
    case (r.command)
      CMD_ADD, CMD_SUB: begin
        p = an * bd;
        p_s = an_s && p != 0;
        q = bn * ad;
        q_s = bn_s && q != 0;
        if (r.command == CMD_SUB && q != 0) q_s = !q_s;
        if (p_s == q_s) begin
          n_s = p_s;
          nm = p + q;
        end else if (p >= q) begin
          n_s = p_s;
          nm = p - q;
        end else begin
          n_s = q_s;
          nm = q - p;
        end
        dm = ad * bd;
      end
      CMD_MUL: begin
        nm = an * bn;
        n_s = (an_s != bn_s);
        dm = ad * bd;
      end
      default: begin
        nm = an * bd;
        n_s = (an_s != bn_s);
        dm = ad * bn;
      end
    endcase
    g = gcd64(nm, dm);
    nm = nm / g;
    dm = dm / g;
    if (nm == 0) n_s = 0;
    if (dm > 64'h7FFF_FFFF || nm > (n_s ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
      o.status = ST_OVF;
      return o;
    end
    o.result_numerator = n_s ? 32'(-nm) : nm[31:0];
    o.result_denominator = dm[30:0];
    return o;
  endfunction

  // Record requests and compare results
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      answer_q.delete();
      fail_count <= 0;
    end else begin
      if (done) begin
        if (answer_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", rsp_o);
          fail_count <= fail_count + 1;
        end else begin
          want = answer_q.pop_front();
          if (rsp_o !== want) begin
            if (fail_count < 10) $display("mismatch: expected %p, got %p", want, rsp_o);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) answer_q.push_back(reduce_fraction(req_i));
    end
  end
endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the rational fraction ALU
// Drives directed corner requests then random ones with varied idling, and
// reports the checker's outcome.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import rfa_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start = 0;
  logic busy, done;
  req_t req_i = '0;
  rsp_t rsp_o;
  int   fail_count, pending;
  int   idle_pct;

  always #4 clk_i = ~clk_i;

  rational_fraction_alu_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .done_o(done), .rsp_o(rsp_o)
  );

  rfa_scoreboard chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .done(done), .rsp_o(rsp_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Pick an operand value, biased toward small and corner values
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 40)) - 20);
      2: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom())};
      3: return 32'($urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF);
      default: return 32'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  // Issue one request and wait until busy falls; start stays high after it
  task automatic send_request(input req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 0;
      @(posedge clk_i);
    end
    req_i <= r;
    start <= 1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  initial begin
    req_t r;
    logic [31:0] corner[6];
    corner = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h3};
    idle_pct = 9;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed corners: zero denominators, divide by zero, overflow, zero result
    for (int k = 0; k < 24; k++) begin
      r.command = 2'(k);
      r.a_numerator = corner[k % 6];
      r.a_denominator = corner[(k / 4 + 1) % 6];
      r.b_numerator = corner[(k / 2 + 2) % 6];
      r.b_denominator = corner[(k + 3) % 6];
      if (k == 0) r.a_denominator = 0;
      if (k == 1) r.b_denominator = 0;
      if (k == 3) r.b_numerator = 0;
      send_request(r);
    end
    for (int k = 0; k < 1250; k++) begin
      idle_pct = (k < 420) ? 9 : (k < 840) ? 50 : 0;
      r.command = 2'($urandom_range(0, 3));
      r.a_numerator = pick_value();
      r.a_denominator = pick_value();
      r.b_numerator = pick_value();
      r.b_denominator = pick_value();
      send_request(r);
    end
    start <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hold a hard limit on run time
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule
